>>> rtl/assert_macros.svh
// Assertion helpers, sampled on the rising edge of clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lexer assertion failed");

`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lexer forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)

`define ASSERT_NEVER(lbl, cond)

`endif

`endif

>>> rtl/enol_pkg.sv
`timescale 1ns / 1ps

package enol_pkg;

  localparam int MANTISSA_BITS_DEF   = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 9;

  // Token kinds
  localparam logic [1:0] KIND_INT = 2'd0;
  localparam logic [1:0] KIND_DEC = 2'd1;
  localparam logic [1:0] KIND_OP  = 2'd2;

  // Characters with special meaning
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [31:0] mantissa;
    logic [3:0]  fraction_digits;
    logic [7:0]  operator_char;
    logic        overflowed;
    logic        last_in_run;
  } out_beat_t;

endpackage

>>> rtl/expression_number_operator_lexer.sv
`timescale 1ns / 1ps
// Channel  Ports                          Beat contents
// -------  -----------------------------  ------------------------------------------
// input    in_valid / in_ready / in_data  one text byte and its end-of-text mark
// output   out_valid / out_ready / out_data  one token (number or operator)
//
// Cycles: one byte is taken per cycle while in_ready is high; its tokens are decided
//   in the same cycle and land in a 4-entry result queue, read out one token per cycle
//   if out_ready is high. A byte that yields number then operator writes both tokens
//   at once; the queue absorbs them, so input stalls only when the queue is near full.
// in_ready is high while the queue has room for two tokens.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to idle.
// A stall on the output holds the queue head; the input keeps going until room runs out.

`include "assert_macros.svh"

module expression_number_operator_lexer #(
  parameter int MANTISSA_BITS       = enol_pkg::MANTISSA_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = enol_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  enol_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output enol_pkg::out_beat_t out_data
);

  localparam int MW     = MANTISSA_BITS;
  localparam int DEPTH  = 4;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Lexer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_INT  = 2'd1;
  localparam logic [1:0] MODE_FRAC = 2'd2;

  // Lexer state
  logic [1:0]    mode_r, mode_nxt;
  logic [MW-1:0] accum_r, accum_nxt;
  logic [3:0]    frac_cnt_r, frac_nxt;
  logic          ovf_r, ovf_nxt;

  // Result queue
  enol_pkg::out_beat_t q_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] q_cnt_r;

  logic                in_fire, out_fire;
  logic [7:0]          ch;
  logic                is_digit, is_num, extend, sat;
  logic [3:0]          dval;
  logic [MW+3:0]       prod;
  logic [MW-1:0]       add_val;
  enol_pkg::out_beat_t tok [2];
  logic [1:0]          n_tok;
  logic [1:0]          push_n;

  // Build a number token from a mode and its accumulated digits.
  function automatic enol_pkg::out_beat_t mk_num(input logic [1:0] mode,
                                                 input logic [MW-1:0] mant,
                                                 input logic [3:0] frac,
                                                 input logic ovf);
    enol_pkg::out_beat_t t;
    logic [MW+31:0]      ext;
    ext               = {32'b0, mant};
    t                 = '0;
    t.token_kind      = (mode == MODE_FRAC) ? enol_pkg::KIND_DEC : enol_pkg::KIND_INT;
    t.mantissa        = ext[31:0];
    t.fraction_digits = (mode == MODE_FRAC) ? frac : 4'd0;
    t.overflowed      = ovf;
    return t;
  endfunction

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign ch       = in_data.character;
  assign is_digit = (ch >= enol_pkg::CHAR_ZERO) && (ch <= enol_pkg::CHAR_NINE);
  assign dval     = 4'(ch - enol_pkg::CHAR_ZERO);
  assign is_num   = (mode_r == MODE_INT) || (mode_r == MODE_FRAC);
  assign extend   = is_num && (is_digit || (mode_r == MODE_INT && ch == enol_pkg::CHAR_POINT));

  // accum * 10 + digit as shift-add; anything above MW bits means saturate.
  assign prod    = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + (MW + 4)'(dval);
  assign sat     = |prod[MW+3:MW];
  assign add_val = sat ? '1 : prod[MW-1:0];

  always_comb begin
    mode_nxt  = is_num ? mode_r : MODE_IDLE;
    accum_nxt = accum_r;
    frac_nxt  = frac_cnt_r;
    ovf_nxt   = ovf_r;
    tok[0]    = '0;
    tok[1]    = '0;
    n_tok     = 2'd0;

    if (ch == enol_pkg::CHAR_NUL) begin
      // Zero byte ends the text: flush any number, emit nothing for the byte.
      if (is_num) begin
        tok[0] = mk_num(mode_r, accum_r, frac_cnt_r, ovf_r);
        n_tok  = 2'd1;
      end
      mode_nxt  = MODE_IDLE;
      accum_nxt = '0;
      frac_nxt  = 4'd0;
      ovf_nxt   = 1'b0;
    end else begin
      if (extend) begin
        if (ch == enol_pkg::CHAR_POINT) begin
          mode_nxt = MODE_FRAC;
        end else if (mode_r == MODE_INT || frac_cnt_r < 4'(MAX_FRACTION_DIGITS)) begin
          accum_nxt = add_val;
          ovf_nxt   = ovf_r | sat;
          if (mode_r == MODE_FRAC) begin
            frac_nxt = frac_cnt_r + 4'd1;
          end
        end
        // fraction digits past the limit: drop
      end else begin
        // Byte ends any open number, then is handled as in idle.
        if (is_num) begin
          tok[0]    = mk_num(mode_r, accum_r, frac_cnt_r, ovf_r);
          n_tok     = 2'd1;
          mode_nxt  = MODE_IDLE;
          accum_nxt = '0;
          frac_nxt  = 4'd0;
          ovf_nxt   = 1'b0;
        end
        if (is_digit) begin
          mode_nxt  = MODE_INT;
          accum_nxt = MW'(dval);
          frac_nxt  = 4'd0;
          ovf_nxt   = 1'b0;
        end else if (ch != enol_pkg::CHAR_SPACE) begin
          tok[n_tok[0]]               = '0;
          tok[n_tok[0]].token_kind    = enol_pkg::KIND_OP;
          tok[n_tok[0]].operator_char = ch;
          n_tok                       = n_tok + 2'd1;
        end
      end

      // Number still open at end of text: flush it last.
      if (in_data.end_of_text && mode_nxt != MODE_IDLE) begin
        tok[n_tok[0]] = mk_num(mode_nxt, accum_nxt, frac_nxt, ovf_nxt);
        n_tok         = n_tok + 2'd1;
        mode_nxt      = MODE_IDLE;
        accum_nxt     = '0;
        frac_nxt      = 4'd0;
        ovf_nxt       = 1'b0;
      end
    end

    // Mark the final token caused by this byte.
    if (n_tok == 2'd2) begin
      tok[1].last_in_run = 1'b1;
    end else if (n_tok == 2'd1) begin
      tok[0].last_in_run = 1'b1;
    end
  end

  assign push_n = in_fire ? n_tok : 2'd0;

  // Lexer state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      accum_r    <= '0;
      frac_cnt_r <= 4'd0;
      ovf_r      <= 1'b0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      accum_r    <= accum_nxt;
      frac_cnt_r <= frac_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Queue storage: payload only, no reset.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_r] <= tok[0];
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_r + PTR_W'(1)] <= tok[1];
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_fire);
      q_cnt_r  <= q_cnt_r + CNT_W'(push_n) - CNT_W'(out_fire);
    end
  end

  assign in_ready  = q_cnt_r <= CNT_W'(DEPTH - 2);
  assign out_valid = q_cnt_r != '0;
  assign out_data  = q_mem[rd_ptr_r];

  `ASSERT_CLK(a_q_bound, q_cnt_r <= CNT_W'(DEPTH))
  `ASSERT_CLK(a_ovf_saturated, ovf_r |-> accum_r == '1)
  `ASSERT_CLK(a_idle_clean, mode_r == MODE_IDLE |-> (accum_r == '0 && frac_cnt_r == 4'd0 && !ovf_r))
  `ASSERT_CLK(a_frac_only_in_frac, frac_cnt_r != 4'd0 |-> mode_r == MODE_FRAC)
  `ASSERT_NEVER(a_frac_limit, frac_cnt_r > 4'(MAX_FRACTION_DIGITS))

endmodule
